@@ rtl/core/percent_encoding_codec_top_assert.svh @@
// Assertion macros shared by the percent encoding codec RTL
`ifndef PERCENT_ENCODING_CODEC_TOP_ASSERT_SVH
`define PERCENT_ENCODING_CODEC_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low
`define PEC_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pec same-cycle check failed");

// Next-cycle implication, clocked on clk, quiet while rst_n is low
`define PEC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pec next-cycle check failed");

`endif

@@ rtl/core/pec_pkg.sv @@
// Package: types, character codes and helper functions for the percent codec
`default_nettype none

package pec_pkg;

    // Character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    // Direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Escape progress in decode mode (code 3 is never produced and acts as idle)
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } hex_phase_t;

    // Result sequencer step in the back end
    typedef enum logic [1:0] {
        STEP_FIRST = 2'd0,
        STEP_HIGH  = 2'd1,
        STEP_LOW   = 2'd2
    } step_t;

    // Job kinds passed from front to back
    typedef enum logic {
        JOB_SINGLE = 1'b0,
        JOB_TRIPLE = 1'b1
    } job_kind_t;

    // One job: a single result, or a three-result escape of data
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic       last;
        logic       err;
    } job_t;

    // Letters and digits pass through the encoder untouched
    function automatic logic is_alnum(input logic [7:0] b);
        return (b inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]});
    endfunction

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b inside {[CH_ZERO:CH_NINE]}) begin
            v = 5'(b - CH_ZERO);
        end else if (b inside {[CH_UP_A:CH_UP_F]}) begin
            v = 5'(b - CH_UP_A + 8'd10);
        end else if (b inside {[CH_LO_A:CH_LO_F]}) begin
            v = 5'(b - CH_LO_A + 8'd10);
        end
        return v;
    endfunction

    // Upper-case hex character for a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = CH_ZERO + {4'd0, n};
        end else begin
            c = CH_UP_A + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/percent_encoding_codec_top.sv @@
// Top level of the streaming percent encoder / decoder
//
//  Channel  | Handshake        | Payload
//  ---------+------------------+---------------------------------------------
//  config   | cfg_we           | cfg_wdata (direction: 0 encode, 1 decode)
//  input    | push / full      | in_byte[7:0], in_last
//  result   | pop / empty      | out_byte[7:0], run_last, string_end, decode_error
//
//  The front end classifies each item as it is accepted; a letter, digit or decoded
//  byte gives one result item, an encoded escape three: a percent and two hex digits.
//  Sustained rate is set by the single result register: one item per cycle for
//  one-result items while pop drains it; an escape holds it for its three items.
//  Front and back are parted by a QUEUE_DEPTH-entry job queue; full follows it.
//  Reset (rst_n low, asynchronous) selects encode mode and empties everything.
`default_nettype none

module percent_encoding_codec_top #(
    parameter int QUEUE_DEPTH = pec_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            string_end,
    output logic            decode_error
);
    import pec_pkg::*;

    job_t fe_job, q_job;
    logic fe_push, q_full, q_empty, q_rd;

    // Classification and decode tracking
    pec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .job_push  (fe_push),
        .job       (fe_job)
    );

    // Job queue
    pec_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_job  (fe_job),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_job  (q_job),
        .q_empty (q_empty)
    );

    // Result expansion
    pec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_job       (q_job),
        .q_empty      (q_empty),
        .rd_en        (q_rd),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .string_end   (string_end),
        .decode_error (decode_error)
    );

endmodule

`default_nettype wire

@@ rtl/core/pec_front.sv @@
// Front end: direction register, decode escape tracking and job classification
`default_nettype none
`include "percent_encoding_codec_top_assert.svh"

module pec_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    input  wire logic         q_full,
    output logic              job_push,
    output pec_pkg::job_t     job
);
    import pec_pkg::*;

    logic       direction_reg;
    hex_phase_t phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       discarding_reg, discarding_next;
    logic       disc_step;
    logic       accept;
    logic       job_valid;
    logic [4:0] hv;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign hv     = hex_value(in_byte);

    // Next decode state; disc_step is the discard flag before end-of-string clearing
    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        disc_step        = discarding_reg;
        if (direction_reg == DIR_DECODE && !discarding_reg) begin
            case (phase_reg)
                PH_HIGH:
                begin
                    if (hv[4]) begin
                        disc_step        = 1'b1;
                        phase_next       = PH_IDLE;
                        high_nibble_next = 4'd0;
                    end else begin
                        high_nibble_next = hv[3:0];
                        phase_next       = PH_LOW;
                        if (in_last) disc_step = 1'b1;
                    end
                end
                PH_LOW:
                begin
                    phase_next       = PH_IDLE;
                    high_nibble_next = 4'd0;
                    if (hv[4]) disc_step = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (in_byte == CH_PERCENT) begin
                        phase_next = PH_HIGH;
                        if (in_last) disc_step = 1'b1;
                    end
                end
            endcase
        end
        discarding_next = disc_step;
        if (in_last) begin
            phase_next       = PH_IDLE;
            high_nibble_next = 4'd0;
            discarding_next  = 1'b0;
        end
    end

    // Job produced by the current item
    always_comb
    begin
        job_valid = 1'b0;
        job       = '{kind: JOB_SINGLE, data: in_byte, last: in_last, err: 1'b0};
        if (direction_reg == DIR_ENCODE) begin
            job_valid = 1'b1;
            job.kind  = is_alnum(in_byte) ? JOB_SINGLE : JOB_TRIPLE;
        end else if (in_last && disc_step) begin
            // swallowed string: one error item
            job_valid = 1'b1;
            job.data  = 8'd0;
            job.err   = 1'b1;
        end else if (!discarding_reg) begin
            case (phase_reg)
                PH_HIGH:
                begin
                    job_valid = 1'b0;
                end
                PH_LOW:
                begin
                    job_valid = !hv[4];
                    job.data  = {high_nibble_reg, hv[3:0]};
                end
                default:
                begin
                    job_valid = (in_byte != CH_PERCENT);
                    job.data  = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
                end
            endcase
        end
    end

    assign job_push = accept && job_valid;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg   <= DIR_ENCODE;
            phase_reg       <= PH_IDLE;
            high_nibble_reg <= 4'd0;
            discarding_reg  <= 1'b0;
        end else if (cfg_we) begin
            direction_reg   <= cfg_wdata;
            phase_reg       <= PH_IDLE;
            high_nibble_reg <= 4'd0;
            discarding_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            discarding_reg  <= discarding_next;
        end
    end

    // Checks
    `PEC_CHECK(a_encode_state_clear, direction_reg == DIR_ENCODE,
               phase_reg == PH_IDLE && !discarding_reg)
    `PEC_CHECK(a_no_escape_while_discarding, discarding_reg, phase_reg == PH_IDLE)

endmodule

`default_nettype wire

@@ rtl/core/pec_job_queue.sv @@
// Short job queue between front and back ends
`default_nettype none
`include "percent_encoding_codec_top_assert.svh"

module pec_job_queue #(
    parameter int DEPTH = pec_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire pec_pkg::job_t wr_job,
    output logic               q_full,
    input  wire logic          rd_en,
    output pec_pkg::job_t      rd_job,
    output logic               q_empty
);
    import pec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Checks
    `PEC_CHECK(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ rtl/core/pec_back.sv @@
// Back end: expands jobs into result items behind an output register
`default_nettype none
`include "percent_encoding_codec_top_assert.svh"

module pec_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pec_pkg::job_t rd_job,
    input  wire logic          q_empty,
    output logic               rd_en,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               string_end,
    output logic               decode_error
);
    import pec_pkg::*;

    step_t      step_reg, step_next;
    job_t       hold_reg;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg, end_reg, err_reg;
    logic       can_load, emit;
    logic [7:0] e_byte;
    logic       e_run_last, e_end, e_err;

    // Output register may take a new item when free or being drained
    assign can_load = !out_valid_reg || pop;

    // Next step
    always_comb
    begin
        step_next = step_reg;
        case (step_reg)
            STEP_FIRST:
            begin
                if (can_load && !q_empty && rd_job.kind == JOB_TRIPLE) begin
                    step_next = STEP_HIGH;
                end
            end
            STEP_HIGH:
            begin
                if (can_load) step_next = STEP_LOW;
            end
            STEP_LOW:
            begin
                if (can_load) step_next = STEP_FIRST;
            end
            default:
            begin
                step_next = STEP_FIRST;
            end
        endcase
    end

    // Item to emit and queue read
    always_comb
    begin
        rd_en      = 1'b0;
        emit       = 1'b0;
        e_byte     = rd_job.data;
        e_run_last = 1'b1;
        e_end      = rd_job.last;
        e_err      = rd_job.err;
        case (step_reg)
            STEP_FIRST:
            begin
                rd_en = can_load && !q_empty;
                emit  = can_load && !q_empty;
                if (rd_job.kind == JOB_TRIPLE) begin
                    e_byte     = CH_PERCENT;
                    e_run_last = 1'b0;
                    e_end      = 1'b0;
                    e_err      = 1'b0;
                end
            end
            STEP_HIGH:
            begin
                emit       = can_load;
                e_byte     = hex_digit(hold_reg.data[7:4]);
                e_run_last = 1'b0;
                e_end      = 1'b0;
                e_err      = 1'b0;
            end
            STEP_LOW:
            begin
                emit       = can_load;
                e_byte     = hex_digit(hold_reg.data[3:0]);
                e_run_last = 1'b1;
                e_end      = hold_reg.last;
                e_err      = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            hold_reg <= rd_job;
        end
        if (emit) begin
            byte_reg     <= e_byte;
            run_last_reg <= e_run_last;
            end_reg      <= e_end;
            err_reg      <= e_err;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = byte_reg;
    assign run_last     = run_last_reg;
    assign string_end   = end_reg;
    assign decode_error = err_reg;

    // Checks
    `PEC_CHECK(a_escape_keeps_output, step_reg != STEP_FIRST, out_valid_reg)
    `PEC_CHECK(a_error_item_shape, out_valid_reg && err_reg,
               run_last_reg && end_reg && byte_reg == 8'd0)
    `PEC_CHECK_NEXT(a_high_then_low, step_reg == STEP_HIGH && can_load, step_reg == STEP_LOW)

endmodule

`default_nettype wire
